### hdl/srwm_pkg.sv
// Package for the session rate window monitor: sizes, divisors and the
// request structs passed between the sequencer, the slot ring and the divider.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srwm_pkg;

    localparam int RING_SLOTS         = 15;
    localparam int INTERVAL_SECONDS   = 20;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int MINUTES_IN_WINDOW  = 5;

    localparam int CNT_W = 32;
    localparam int TOT_W = 64;
    localparam int POS_W = $clog2(RING_SLOTS);
    localparam int SUM_W = CNT_W + $clog2(RING_SLOTS);

    // Slots that fall within the newest minute, newest slot first.
    localparam int MIN_SLOTS_RAW = (SECONDS_PER_MINUTE + INTERVAL_SECONDS - 1)
                                   / INTERVAL_SECONDS;
    localparam int MIN_SLOTS = (MIN_SLOTS_RAW > RING_SLOTS) ? RING_SLOTS : MIN_SLOTS_RAW;

    localparam int DIV_LAST = INTERVAL_SECONDS;
    localparam int DIV_MIN  = INTERVAL_SECONDS * (SECONDS_PER_MINUTE / INTERVAL_SECONDS);
    localparam int DIV_ALL  = DIV_MIN * MINUTES_IN_WINDOW;

    // Each division by a constant is a multiplication by the rounded-up
    // reciprocal followed by a right shift. The product is exact for every
    // dividend below 2^SUM_W because no divisor exceeds 2^(RCP_SHIFT - SUM_W).
    localparam int RCP_SHIFT  = SUM_W + $clog2(DIV_ALL);
    localparam int CHUNK_W    = 16;
    localparam int MUL_CHUNKS = (RCP_SHIFT + CHUNK_W) / CHUNK_W;
    localparam int MUL_W      = MUL_CHUNKS * CHUNK_W;
    localparam int STEP_W     = $clog2(MUL_CHUNKS);

    localparam logic [MUL_W-1:0] RCP_LAST =
        MUL_W'(((64'd1 << RCP_SHIFT) + 64'(DIV_LAST) - 64'd1) / 64'(DIV_LAST));
    localparam logic [MUL_W-1:0] RCP_MIN  =
        MUL_W'(((64'd1 << RCP_SHIFT) + 64'(DIV_MIN) - 64'd1) / 64'(DIV_MIN));
    localparam logic [MUL_W-1:0] RCP_ALL  =
        MUL_W'(((64'd1 << RCP_SHIFT) + 64'(DIV_ALL) - 64'd1) / 64'(DIV_ALL));

    typedef enum logic [1:0] {
        CMD_CREATED   = 2'd0,
        CMD_DESTROYED = 2'd1,
        CMD_TICK      = 2'd2
    } t_cmd;

    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
    } t_ring_req;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [MUL_W-1:0] recip;
    } t_div_req;

endpackage

`default_nettype wire

### hdl/srwm_ring.sv
// Ring of per-interval created counts: one write port, one registered read.
// Depends on srwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srwm_ring
    import srwm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_ring_req        i_req,
    output logic      [CNT_W-1:0] o_rd_data
);

    logic [CNT_W-1:0]      r_mem [RING_SLOTS];
    logic [RING_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]      r_rd_data;

    // A slot never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/srwm_div.sv
// Shared divider by a constant: the dividend is multiplied by the divisor's
// reciprocal, one 16-bit slice of it per cycle. Depends on srwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srwm_div
    import srwm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic      [SUM_W-1:0] o_quotient,
    output logic                  o_done
);

    localparam int PART_W  = SUM_W + CHUNK_W + 1;
    localparam int PROD_W  = SUM_W + CHUNK_W;
    localparam int QUO_LSB = RCP_SHIFT - CHUNK_W * (MUL_CHUNKS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MUL_CHUNKS - 1);

    logic [SUM_W-1:0]  r_dvd;
    logic [MUL_W-1:0]  r_rcp;
    logic [PART_W-1:0] r_part;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [PROD_W-1:0] prod;

    // Slices are taken lowest first; the partial sum drops the bits that sit
    // below the next slice, which keeps the carries exact.
    always_comb begin
        prod = PROD_W'(r_dvd) * PROD_W'(r_rcp[CHUNK_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_dvd  <= i_req.dividend;
                r_rcp  <= i_req.recip;
                r_part <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_part <= (r_part >> CHUNK_W) + PART_W'(prod);
                r_rcp  <= r_rcp >> CHUNK_W;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_part[QUO_LSB +: SUM_W];
    assign o_done     = r_done;

endmodule

`default_nettype wire

### hdl/session_rate_window_monitor_unit.sv
// Top level of the session rate window monitor: event counters, tick sequencer,
// slot ring and shared divider. Depends on srwm_pkg, srwm_ring and srwm_div.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Handshake                 Payload
//  -------   -----------------------   ----------------------------------------
//  input     i_in_valid / o_in_ready   i_command, i_now_ticks
//  output    o_out_valid / i_out_ready  o_rate_last_interval, o_rate_one_minute,
//                                      o_rate_five_minutes, o_rate_peak,
//                                      o_peak_time, o_created_sum, o_destroyed_sum
//
//  Created or destroyed items may follow each other in every cycle while the
//  unit is idle; a tick holds o_in_ready low until its results are loaded into
//  the output register. During a tick the ring is read one slot a cycle, and
//  the four rates then pass one after another through the single divider, which
//  multiplies by the divisor's reciprocal one 16-bit slice a cycle. Reset is
//  synchronous and active low; it clears the event counters, the totals, the peak
//  and the slot valid bits at once, with no clearing pass.
//  A result waiting in the output register does not stop created or destroyed
//  items; a later tick completes its work and then waits for the output to free.
module session_rate_window_monitor_unit
    import srwm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_command,
    input  wire logic [CNT_W-1:0] i_now_ticks,

    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic      [CNT_W-1:0] o_rate_last_interval,
    output logic      [CNT_W-1:0] o_rate_one_minute,
    output logic      [CNT_W-1:0] o_rate_five_minutes,
    output logic      [CNT_W-1:0] o_rate_peak,
    output logic      [CNT_W-1:0] o_peak_time,
    output logic      [TOT_W-1:0] o_created_sum,
    output logic      [TOT_W-1:0] o_destroyed_sum
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DRAIN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    // Which rate the divider is working on.
    localparam logic [1:0] RATE_LAST = 2'd0;
    localparam logic [1:0] RATE_MIN  = 2'd1;
    localparam logic [1:0] RATE_ALL  = 2'd2;
    localparam logic [1:0] RATE_PEAK = 2'd3;

    localparam logic [POS_W-1:0] LAST_POS    = POS_W'(RING_SLOTS - 1);
    localparam logic [POS_W:0]   MIN_SLOTS_V = (POS_W + 1)'(MIN_SLOTS);
    localparam logic [CNT_W-1:0] CNT_MAX     = '1;

    t_state r_state;

    logic [CNT_W-1:0] r_pend_c;
    logic [CNT_W-1:0] r_pend_d;
    logic [TOT_W-1:0] r_tot_c;
    logic [TOT_W-1:0] r_tot_d;
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_peak_cnt;
    logic [CNT_W-1:0] r_peak_stamp;
    logic [CNT_W-1:0] r_last_cnt;

    logic [POS_W-1:0] r_n;
    logic [POS_W-1:0] r_idx;
    logic             r_rd_pend;
    logic [POS_W-1:0] r_rd_n;
    logic [SUM_W-1:0] r_sum_min;
    logic [SUM_W-1:0] r_sum_all;

    logic [1:0]       r_sel;
    logic [CNT_W-1:0] r_rate [4];

    logic             r_out_valid;
    logic [CNT_W-1:0] r_o_last;
    logic [CNT_W-1:0] r_o_min;
    logic [CNT_W-1:0] r_o_all;
    logic [CNT_W-1:0] r_o_peak;
    logic [CNT_W-1:0] r_o_time;
    logic [TOT_W-1:0] r_o_tot_c;
    logic [TOT_W-1:0] r_o_tot_d;

    logic             accept;
    logic             is_tick;
    t_ring_req        ring_req;
    logic [CNT_W-1:0] ring_rd_data;
    t_div_req         div_req;
    logic [SUM_W-1:0] div_quotient;
    logic             div_done;
    logic [CNT_W-1:0] n_rate;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] n_idx;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_tick    = (i_command == CMD_TICK);

    // The ring position advances with wrap; the read index walks backwards
    // from the newest slot, also with wrap.
    assign n_pos = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
    assign n_idx = (r_idx == '0) ? LAST_POS : r_idx - 1'b1;

    always_comb begin
        ring_req.wr_en   = accept && is_tick;
        ring_req.wr_addr = r_pos;
        ring_req.wr_data = r_pend_c;
        ring_req.rd_en   = (r_state == S_SUM);
        ring_req.rd_addr = r_idx;
    end

    srwm_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ring_req),
        .o_rd_data (ring_rd_data)
    );

    // Operand selection for the shared divider. The selection holds steady
    // for the whole division, so it also serves the zero test below.
    always_comb begin
        div_req.start = (r_state == S_DIV_GO);
        case (r_sel)
            RATE_LAST: begin
                div_req.dividend = SUM_W'(r_last_cnt);
                div_req.recip    = RCP_LAST;
            end
            RATE_MIN: begin
                div_req.dividend = r_sum_min;
                div_req.recip    = RCP_MIN;
            end
            RATE_ALL: begin
                div_req.dividend = r_sum_all;
                div_req.recip    = RCP_ALL;
            end
            default: begin
                div_req.dividend = SUM_W'(r_peak_cnt);
                div_req.recip    = RCP_LAST;
            end
        endcase
    end

    srwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_quotient (div_quotient),
        .o_done     (div_done)
    );

    // A zero count gives a zero rate, a count below the divisor gives one, and
    // a quotient too wide for the port saturates.
    always_comb begin
        if (div_req.dividend == '0) begin
            n_rate = '0;
        end else if (div_quotient == '0) begin
            n_rate = CNT_W'(1);
        end else if (|div_quotient[SUM_W-1:CNT_W]) begin
            n_rate = CNT_MAX;
        end else begin
            n_rate = div_quotient[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_c     <= '0;
            r_pend_d     <= '0;
            r_tot_c      <= '0;
            r_tot_d      <= '0;
            r_pos        <= '0;
            r_peak_cnt   <= '0;
            r_peak_stamp <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == S_SUM);
            r_rd_n    <= r_n;

            // Slot data arrives in the cycle after its read was issued.
            if (r_rd_pend) begin
                r_sum_all <= r_sum_all + SUM_W'(ring_rd_data);
                if ({1'b0, r_rd_n} < MIN_SLOTS_V) begin
                    r_sum_min <= r_sum_min + SUM_W'(ring_rd_data);
                end
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_command)
                            CMD_CREATED: begin
                                if (r_pend_c != CNT_MAX) begin
                                    r_pend_c <= r_pend_c + 1'b1;
                                end
                            end
                            CMD_DESTROYED: begin
                                if (r_pend_d != CNT_MAX) begin
                                    r_pend_d <= r_pend_d + 1'b1;
                                end
                            end
                            CMD_TICK: begin
                                r_pend_c   <= '0;
                                r_pend_d   <= '0;
                                r_tot_c    <= r_tot_c + TOT_W'(r_pend_c);
                                r_tot_d    <= r_tot_d + TOT_W'(r_pend_d);
                                r_last_cnt <= r_pend_c;
                                r_idx      <= r_pos;
                                r_pos      <= n_pos;
                                r_n        <= '0;
                                r_sum_min  <= '0;
                                r_sum_all  <= '0;
                                r_sel      <= RATE_LAST;
                                if (r_pend_c > r_peak_cnt) begin
                                    r_peak_cnt   <= r_pend_c;
                                    r_peak_stamp <= i_now_ticks;
                                end
                                r_state    <= S_SUM;
                            end
                            default: begin
                                // The unused command is dropped without effect.
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    r_idx <= n_idx;
                    r_n   <= r_n + 1'b1;
                    if (r_n == LAST_POS) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_rate[r_sel] <= n_rate;
                        if (r_sel == RATE_PEAK) begin
                            r_state <= S_OUT;
                        end else begin
                            r_sel   <= r_sel + 1'b1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_o_last    <= r_rate[RATE_LAST];
                        r_o_min     <= r_rate[RATE_MIN];
                        r_o_all     <= r_rate[RATE_ALL];
                        r_o_peak    <= r_rate[RATE_PEAK];
                        r_o_time    <= r_peak_stamp;
                        r_o_tot_c   <= r_tot_c;
                        r_o_tot_d   <= r_tot_d;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_rate_last_interval = r_o_last;
    assign o_rate_one_minute    = r_o_min;
    assign o_rate_five_minutes  = r_o_all;
    assign o_rate_peak          = r_o_peak;
    assign o_peak_time          = r_o_time;
    assign o_created_sum        = r_o_tot_c;
    assign o_destroyed_sum      = r_o_tot_d;

endmodule

`default_nettype wire
